FILE: rtl/core/nrpp_pkg.sv
// Package with the constants, codes, types and header table of the RMC position parser.
package nrpp_pkg;

  localparam int BYTE_W = 8;
  localparam int STATUS_W = 2;
  localparam int SEC_W = 28;
  localparam int DEG_W = 16;
  localparam int MIN_W = 13;
  localparam int FRAC_W = 19;
  localparam int DIGIT_W = 9;
  localparam int PROD3_W = 21;
  localparam int X_W = 18;
  localparam int Q_W = 12;
  localparam int RECIP = 268436;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W = X_W + 19;

  localparam logic [2:0] HDR_LEN = 3'd7;
  localparam logic [2:0] LAT_COMMA = 3'd2;
  localparam logic [2:0] LON_COMMA = 3'd4;
  localparam logic [2:0] COMMA_MAX = 3'd7;

  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PARSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] OUT_OPEN = 2'd0;
  localparam logic [1:0] OUT_REJECT = 2'd1;
  localparam logic [1:0] OUT_EMPTY = 2'd2;

  typedef struct packed {
    logic                       res;
    logic [STATUS_W-1:0]        status;
    logic                       job;
    logic                       lon;
    logic                       neg;
    logic signed [DEG_W-1:0]    deg;
    logic signed [MIN_W-1:0]    minute;
    logic signed [FRAC_W-1:0]   frac;
  } stage1_t;

  typedef struct packed {
    logic                       res;
    logic [STATUS_W-1:0]        status;
    logic                       job;
    logic                       lon;
    logic signed [SEC_W-1:0]    whole;
    logic [X_W-1:0]             x;
    logic                       qneg;
  } stage2_t;

  function automatic logic [BYTE_W-1:0] hdr_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] ch;
    case (pos)
      3'd0: ch = 8'h24;
      3'd1: ch = 8'h47;
      3'd2: ch = 8'h50;
      3'd3: ch = 8'h52;
      3'd4: ch = 8'h4D;
      3'd5: ch = 8'h43;
      3'd6: ch = 8'h2C;
      default: ch = 8'h2C;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/core/nrpp_ifs.sv
// Valid/ready channel interfaces for sentence bytes and parse results.
interface nrpp_in_if;
  logic                             valid;
  logic                             ready;
  logic [nrpp_pkg::BYTE_W-1:0]      data_byte;
  logic                             last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface nrpp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [nrpp_pkg::STATUS_W-1:0]        status;
  logic signed [nrpp_pkg::SEC_W-1:0]    latitude_seconds;
  logic signed [nrpp_pkg::SEC_W-1:0]    longitude_seconds;

  modport source (output valid, output status, output latitude_seconds,
                  output longitude_seconds, input ready);
  modport sink (input valid, input status, input latitude_seconds,
                input longitude_seconds, output ready);
endinterface

FILE: rtl/core/nmea_rmc_position_parser_unit.sv
// Top level of the RMC sentence position parser with its scaling pipeline.
//
//   Channel  Dir  Word                                           Accepted when
//   in_i     in   data_byte, last                                 valid && ready
//   out_o    out  status, latitude_seconds, longitude_seconds     valid && ready
//
// A byte is taken each cycle unless stalled; parser state updates when it is taken.
// The last byte of a sentence loads its result into the parse register.
// The path runs through the parse register, the scaling register and the output register.
// The reciprocal multiply for the fraction seconds sits in front of the output register.
// Reset clears the parser state, the position registers and all valid flags.
// Input stalls only when the parse register is full, the scaling register holds a result
// and the output register holds a result that the receiver has not taken.
module nmea_rmc_position_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  nrpp_in_if.sink       in_i,
  nrpp_out_if.source    out_o
);

  logic [2:0]                           hdr_pos_q, hdr_pos_d;
  logic [2:0]                           comma_q, comma_d;
  logic [3:0]                           fpos_q, fpos_d;
  logic                                 fneg_q, fneg_d;
  logic signed [nrpp_pkg::DEG_W-1:0]    deg_q, deg_d;
  logic signed [nrpp_pkg::MIN_W-1:0]    min_q, min_d;
  logic signed [nrpp_pkg::FRAC_W-1:0]   frac_q, frac_d;
  logic [1:0]                           outcome_q, outcome_d;

  logic signed [nrpp_pkg::DIGIT_W-1:0]  digit;
  logic [3:0]                           cpos;
  logic [3:0]                           deg_n;
  logic                                 lon_fld;
  logic                                 in_acc;
  logic                                 in_ready;

  nrpp_pkg::stage1_t                    st1_q, st1_d;
  nrpp_pkg::stage2_t                    st2_q, st2_d;
  logic                                 st1_v_q, st2_v_q;
  logic                                 st1_move, st2_move;

  logic signed [nrpp_pkg::DEG_W-1:0]    s_deg;
  logic signed [nrpp_pkg::MIN_W-1:0]    s_min;
  logic signed [nrpp_pkg::FRAC_W-1:0]   s_frac;
  logic signed [nrpp_pkg::SEC_W-1:0]    whole;
  logic signed [nrpp_pkg::PROD3_W-1:0]  p3;
  logic [nrpp_pkg::PROD3_W-1:0]         p3_abs;

  logic [nrpp_pkg::PROD_W-1:0]          prod;
  logic [nrpp_pkg::Q_W-1:0]             q;
  logic signed [nrpp_pkg::SEC_W-1:0]    q_ext;
  logic signed [nrpp_pkg::SEC_W-1:0]    comp;

  logic signed [nrpp_pkg::SEC_W-1:0]    lat_val_q, lon_val_q;
  logic                                 out_v_q;
  logic [nrpp_pkg::STATUS_W-1:0]        out_status_q;
  logic signed [nrpp_pkg::SEC_W-1:0]    out_lat_q, out_lon_q;

  // Handshake and stage movement.
  assign st2_move = st2_v_q && (!st2_q.res || !out_v_q || out_o.ready);
  assign st1_move = st1_v_q && (!st2_v_q || st2_move);
  assign in_ready = !st1_v_q || st1_move;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign digit   = $signed({1'b0, in_i.data_byte}) - $signed({1'b0, nrpp_pkg::CHAR_ZERO});
  assign cpos    = fpos_q - 4'd1;
  assign lon_fld = (comma_q == nrpp_pkg::LON_COMMA + 3'd1);
  assign deg_n   = lon_fld ? 4'd3 : 4'd2;

  // Sentence parser.
  always_comb begin
    hdr_pos_d = hdr_pos_q;
    comma_d   = comma_q;
    fpos_d    = fpos_q;
    fneg_d    = fneg_q;
    deg_d     = deg_q;
    min_d     = min_q;
    frac_d    = frac_q;
    outcome_d = outcome_q;
    st1_d     = '0;
    if (in_acc) begin
      if (outcome_q == nrpp_pkg::OUT_OPEN) begin
        if (hdr_pos_q != nrpp_pkg::HDR_LEN) begin
          if (in_i.data_byte != nrpp_pkg::hdr_char(hdr_pos_q)) begin
            outcome_d = nrpp_pkg::OUT_REJECT;
          end else begin
            hdr_pos_d = hdr_pos_q + 3'd1;
            if (hdr_pos_d == nrpp_pkg::HDR_LEN) begin
              comma_d = 3'd1;
            end
          end
        end else if (fpos_q != 4'd0) begin
          if (fpos_q == 4'd1 && !fneg_q && in_i.data_byte == nrpp_pkg::CHAR_COMMA) begin
            outcome_d = nrpp_pkg::OUT_EMPTY;
          end else if (fpos_q == 4'd1 && !fneg_q &&
                       in_i.data_byte == nrpp_pkg::CHAR_MINUS) begin
            fneg_d = 1'b1;
          end else begin
            if (cpos < deg_n) begin
              deg_d = deg_q * 16'sd10 + nrpp_pkg::DEG_W'(digit);
            end else if (cpos < deg_n + 4'd2) begin
              min_d = min_q * 13'sd10 + nrpp_pkg::MIN_W'(digit);
            end else if (cpos > deg_n + 4'd2) begin
              frac_d = frac_q * 19'sd10 + nrpp_pkg::FRAC_W'(digit);
            end
            if (cpos == deg_n + 4'd6) begin
              st1_d.job    = 1'b1;
              st1_d.lon    = lon_fld;
              st1_d.neg    = fneg_d;
              st1_d.deg    = deg_d;
              st1_d.minute = min_d;
              st1_d.frac   = frac_d;
              fpos_d = 4'd0;
              fneg_d = 1'b0;
              deg_d  = '0;
              min_d  = '0;
              frac_d = '0;
            end else begin
              fpos_d = fpos_q + 4'd1;
            end
          end
        end else if (in_i.data_byte == nrpp_pkg::CHAR_COMMA) begin
          if (comma_q == nrpp_pkg::LAT_COMMA || comma_q == nrpp_pkg::LON_COMMA) begin
            fpos_d = 4'd1;
          end
          if (comma_q != nrpp_pkg::COMMA_MAX) begin
            comma_d = comma_q + 3'd1;
          end
        end
      end
      if (in_i.last) begin
        st1_d.res = 1'b1;
        if (outcome_d == nrpp_pkg::OUT_REJECT) begin
          st1_d.status = nrpp_pkg::ST_REJECT;
        end else if (outcome_d == nrpp_pkg::OUT_EMPTY) begin
          st1_d.status = nrpp_pkg::ST_EMPTY;
        end else if (hdr_pos_d != nrpp_pkg::HDR_LEN || fpos_d != 4'd0) begin
          st1_d.status = nrpp_pkg::ST_REJECT;
        end else begin
          st1_d.status = nrpp_pkg::ST_PARSED;
        end
        hdr_pos_d = '0;
        comma_d   = '0;
        fpos_d    = '0;
        fneg_d    = 1'b0;
        deg_d     = '0;
        min_d     = '0;
        frac_d    = '0;
        outcome_d = nrpp_pkg::OUT_OPEN;
      end
    end
  end

  // Scaling stage: whole seconds and the magnitude of the fraction term.
  assign s_deg  = st1_q.deg;
  assign s_min  = st1_q.minute;
  assign s_frac = st1_q.frac;
  assign whole  = nrpp_pkg::SEC_W'(s_deg) * 28'sd3600 + nrpp_pkg::SEC_W'(s_min) * 28'sd60;
  assign p3     = nrpp_pkg::PROD3_W'(s_frac) * 21'sd3;
  assign p3_abs = p3[nrpp_pkg::PROD3_W-1] ? nrpp_pkg::PROD3_W'(-p3) : nrpp_pkg::PROD3_W'(p3);

  always_comb begin
    st2_d        = '0;
    st2_d.res    = st1_q.res;
    st2_d.status = st1_q.status;
    st2_d.job    = st1_q.job;
    st2_d.lon    = st1_q.lon;
    st2_d.whole  = st1_q.neg ? -whole : whole;
    st2_d.x      = p3_abs[nrpp_pkg::PROD3_W-2:2];
    st2_d.qneg   = st1_q.neg ^ p3[nrpp_pkg::PROD3_W-1];
  end

  // Fraction seconds: floor(x / 125) through a reciprocal multiply.
  assign prod  = nrpp_pkg::PROD_W'(st2_q.x) * nrpp_pkg::PROD_W'(nrpp_pkg::RECIP);
  assign q     = prod[nrpp_pkg::RECIP_SHIFT +: nrpp_pkg::Q_W];
  assign q_ext = $signed(nrpp_pkg::SEC_W'(q));
  assign comp  = st2_q.whole + (st2_q.qneg ? -q_ext : q_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
      comma_q   <= '0;
      fpos_q    <= '0;
      fneg_q    <= 1'b0;
      deg_q     <= '0;
      min_q     <= '0;
      frac_q    <= '0;
      outcome_q <= nrpp_pkg::OUT_OPEN;
      st1_v_q   <= 1'b0;
      st2_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
      lat_val_q <= '0;
      lon_val_q <= '0;
    end else begin
      hdr_pos_q <= hdr_pos_d;
      comma_q   <= comma_d;
      fpos_q    <= fpos_d;
      fneg_q    <= fneg_d;
      deg_q     <= deg_d;
      min_q     <= min_d;
      frac_q    <= frac_d;
      outcome_q <= outcome_d;
      if (in_ready) begin
        st1_v_q <= in_acc && (st1_d.job || st1_d.res);
      end
      if (!st2_v_q || st2_move) begin
        st2_v_q <= st1_v_q;
      end
      if (st2_move && st2_q.res) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (st2_move) begin
        if (st2_q.res) begin
          lat_val_q <= '0;
          lon_val_q <= '0;
        end else if (st2_q.job && !st2_q.lon) begin
          lat_val_q <= comp;
        end else if (st2_q.job) begin
          lon_val_q <= comp;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st1_q <= st1_d;
    end
    if (!st2_v_q || st2_move) begin
      st2_q <= st2_d;
    end
    if (st2_move && st2_q.res) begin
      out_status_q <= st2_q.status;
      out_lat_q    <= (st2_q.job && !st2_q.lon) ? comp : lat_val_q;
      out_lon_q    <= (st2_q.job && st2_q.lon) ? comp : lon_val_q;
    end
  end

  assign out_o.valid             = out_v_q;
  assign out_o.status            = out_status_q;
  assign out_o.latitude_seconds  = out_lat_q;
  assign out_o.longitude_seconds = out_lon_q;

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last |=> hdr_pos_q == '0 && comma_q == '0 && fpos_q == '0 &&
      outcome_q == nrpp_pkg::OUT_OPEN)
    else $error("Parser state was not cleared after the last word of a sentence.");

  a_field_after_comma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpos_q != 4'd0 |-> hdr_pos_q == nrpp_pkg::HDR_LEN &&
      (comma_q == nrpp_pkg::LAT_COMMA + 3'd1 || comma_q == nrpp_pkg::LON_COMMA + 3'd1))
    else $error("A position field is open outside the latitude or longitude slot.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> st1_v_q && st2_v_q && st2_q.res && out_v_q && !out_o.ready)
    else $error("Input stalled without a blocked result ahead of it.");

  a_values_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st2_move && st2_q.res |=> lat_val_q == '0 && lon_val_q == '0)
    else $error("Position registers were not cleared after a result left the pipeline.");

endmodule
